// ----- design/mmee_pkg.sv -----
package mmee_pkg;

    localparam int DIM_DEFAULT = 16;

    localparam int CMD_W   = 2;
    localparam int IDX_W   = 4;
    localparam int VALUE_W = 16;
    localparam int PROD_W  = 2 * VALUE_W;
    localparam int ACC_W   = 40;

    typedef logic [CMD_W-1:0] cmd_t;

    localparam cmd_t CMD_WRITE_A = 2'd0;
    localparam cmd_t CMD_WRITE_B = 2'd1;
    localparam cmd_t CMD_READ    = 2'd2;

    // Sideband that travels with one pair of operands through the MAC
    typedef struct packed {
        logic valid;
        logic first;
        logic last;
    } mac_ctl_t;

endpackage

// ----- design/mmee_store.sv -----
module mmee_store #(
    parameter int DIM = mmee_pkg::DIM_DEFAULT,
    parameter int AW  = $clog2(DIM * DIM)
) (
    input  logic                                aclk,
    input  logic                                we_a,
    input  logic                                we_b,
    input  logic [AW-1:0]                       wr_addr,
    input  logic signed [mmee_pkg::VALUE_W-1:0] wr_data,
    input  logic [AW-1:0]                       rd_addr_a,
    input  logic [AW-1:0]                       rd_addr_b,
    output logic signed [mmee_pkg::VALUE_W-1:0] rd_data_a,
    output logic signed [mmee_pkg::VALUE_W-1:0] rd_data_b
);
    import mmee_pkg::*;

    logic signed [VALUE_W-1:0] mem_a [DIM*DIM];
    logic signed [VALUE_W-1:0] mem_b [DIM*DIM];

    always_ff @(posedge aclk) begin
        if (we_a) begin
            mem_a[wr_addr] <= wr_data;
        end
        rd_data_a <= mem_a[rd_addr_a];
    end

    always_ff @(posedge aclk) begin
        if (we_b) begin
            mem_b[wr_addr] <= wr_data;
        end
        rd_data_b <= mem_b[rd_addr_b];
    end

endmodule

// ----- design/mmee_mac.sv -----
module mmee_mac (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  mmee_pkg::mac_ctl_t                  ctl_in,
    input  logic signed [mmee_pkg::VALUE_W-1:0] a_data,
    input  logic signed [mmee_pkg::VALUE_W-1:0] b_data,
    output logic signed [mmee_pkg::ACC_W-1:0]   acc,
    output logic                                done
);
    import mmee_pkg::*;

    logic signed [PROD_W-1:0] prod_reg;
    mac_ctl_t                 ctl_reg;
    logic signed [ACC_W-1:0]  acc_reg;
    logic signed [ACC_W-1:0]  acc_next;
    logic signed [ACC_W-1:0]  prod_ext;
    logic                     done_reg;

    assign prod_ext = ACC_W'(prod_reg);
    assign acc_next = ctl_reg.first ? prod_ext : acc_reg + prod_ext;

    always_ff @(posedge aclk) begin
        prod_reg <= PROD_W'(a_data) * PROD_W'(b_data);
        if (ctl_reg.valid) begin
            acc_reg <= acc_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ctl_reg  <= '0;
            done_reg <= 1'b0;
        end else begin
            ctl_reg  <= ctl_in;
            done_reg <= ctl_reg.valid && ctl_reg.last;
        end
    end

    assign acc  = acc_reg;
    assign done = done_reg;

endmodule

// ----- design/matrix_multiply_element_engine.sv -----
// Matrix multiply element engine: holds two DIM by DIM signed Q8.8 matrices
// A and B and returns single elements of the product A * B.
//
// Input channel (s_): command, row, col, value. A write of A or B stores one
// element and gives no result; writes with row or col at DIM or above, and
// the unused command code, are dropped. A read returns one item on the m_
// channel: the exact 40-bit dot product (16 fraction bits) of row of A
// with column of B, with the indices echoed; an out-of-range read returns
// zero.
//
// A read walks k through one shared multiply-accumulate unit fed from two
// one-port-read synchronous memories, one term per cycle. s_ready is low
// from a read's accept until its sum is loaded into the output register.
// Writes are accepted back to back. A pending result sits in the output
// register while new writes and the next read proceed; only a finished
// read that finds the output register still full waits, holding s_ready
// low until m_ready.
// Reset (aresetn, synchronous) empties the pipeline and the output
// register; matrix contents are undefined until written.
module matrix_multiply_element_engine #(
    parameter int DIM = mmee_pkg::DIM_DEFAULT
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                s_valid,
    output logic                                s_ready,
    input  logic [mmee_pkg::CMD_W-1:0]          s_command,
    input  logic [mmee_pkg::IDX_W-1:0]          s_row,
    input  logic [mmee_pkg::IDX_W-1:0]          s_col,
    input  logic signed [mmee_pkg::VALUE_W-1:0] s_value,
    output logic                                m_valid,
    input  logic                                m_ready,
    output logic signed [mmee_pkg::ACC_W-1:0]   m_product_value,
    output logic [mmee_pkg::IDX_W-1:0]          m_out_row,
    output logic [mmee_pkg::IDX_W-1:0]          m_out_col
);
    import mmee_pkg::*;

    localparam int AW = $clog2(DIM * DIM);
    localparam int KW = (DIM > 1) ? $clog2(DIM) : 1;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_RUN,
        ST_HOLD
    } state_t;

    state_t                   state_reg;
    logic                     issuing_reg;
    logic [KW-1:0]            k_reg;
    logic [AW-1:0]            addr_a_reg;
    logic [AW-1:0]            addr_b_reg;
    logic                     zero_reg;
    logic [IDX_W-1:0]         req_row_reg;
    logic [IDX_W-1:0]         req_col_reg;
    mac_ctl_t                 mac_ctl_reg;
    logic                     m_valid_reg;
    logic signed [ACC_W-1:0]  m_product_reg;
    logic [IDX_W-1:0]         m_row_reg;
    logic [IDX_W-1:0]         m_col_reg;

    logic                     accept;
    logic                     in_range;
    logic                     we_a;
    logic                     we_b;
    logic [AW-1:0]            wr_addr;
    logic signed [VALUE_W-1:0] rd_data_a;
    logic signed [VALUE_W-1:0] rd_data_b;
    logic signed [ACC_W-1:0]  acc;
    logic                     mac_done;
    logic                     out_free;
    logic                     load_out;
    logic                     k_last;
    logic signed [ACC_W-1:0]  result;

    assign s_ready  = (state_reg == ST_IDLE);
    assign accept   = s_valid && s_ready;
    assign in_range = (32'(s_row) < DIM) && (32'(s_col) < DIM);
    assign wr_addr  = AW'(AW'(s_row) * AW'(DIM) + AW'(s_col));
    assign we_a     = accept && (s_command == CMD_WRITE_A) && in_range;
    assign we_b     = accept && (s_command == CMD_WRITE_B) && in_range;
    assign out_free = !m_valid_reg || m_ready;
    // move a finished sum into the output register
    assign load_out = out_free && (((state_reg == ST_RUN) && mac_done) ||
                                   (state_reg == ST_HOLD));
    assign k_last   = (k_reg == KW'(DIM - 1));
    assign result   = zero_reg ? '0 : acc;

    mmee_store #(
        .DIM (DIM),
        .AW  (AW)
    ) u_store (
        .aclk      (aclk),
        .we_a      (we_a),
        .we_b      (we_b),
        .wr_addr   (wr_addr),
        .wr_data   (s_value),
        .rd_addr_a (addr_a_reg),
        .rd_addr_b (addr_b_reg),
        .rd_data_a (rd_data_a),
        .rd_data_b (rd_data_b)
    );

    mmee_mac u_mac (
        .aclk    (aclk),
        .aresetn (aresetn),
        .ctl_in  (mac_ctl_reg),
        .a_data  (rd_data_a),
        .b_data  (rd_data_b),
        .acc     (acc),
        .done    (mac_done)
    );

    // Read addresses, request fields and output register data
    always_ff @(posedge aclk) begin
        if (accept && (s_command == CMD_READ)) begin
            req_row_reg <= s_row;
            req_col_reg <= s_col;
            zero_reg    <= !in_range;
            // out-of-range reads still sweep, from entry zero
            addr_a_reg  <= in_range ? AW'(AW'(s_row) * AW'(DIM)) : '0;
            addr_b_reg  <= in_range ? AW'(s_col) : '0;
            k_reg       <= '0;
        end else if (issuing_reg) begin
            addr_a_reg  <= addr_a_reg + AW'(1);
            addr_b_reg  <= addr_b_reg + AW'(DIM);
            k_reg       <= k_reg + KW'(1);
        end
        if (load_out) begin
            m_product_reg <= result;
            m_row_reg     <= req_row_reg;
            m_col_reg     <= req_col_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            issuing_reg <= 1'b0;
            mac_ctl_reg <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            mac_ctl_reg.valid <= issuing_reg;
            mac_ctl_reg.first <= (k_reg == '0);
            mac_ctl_reg.last  <= k_last;
            if (load_out) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
            case (state_reg)
                ST_IDLE: begin
                    if (accept && (s_command == CMD_READ)) begin
                        state_reg   <= ST_RUN;
                        issuing_reg <= 1'b1;
                    end
                end
                ST_RUN: begin
                    if (issuing_reg && k_last) begin
                        issuing_reg <= 1'b0;
                    end
                    if (mac_done) begin
                        if (out_free) begin
                            state_reg <= ST_IDLE;
                        end else begin
                            state_reg <= ST_HOLD;
                        end
                    end
                end
                ST_HOLD: begin
                    if (out_free) begin
                        state_reg <= ST_IDLE;
                    end
                end
                default: begin
                    state_reg   <= ST_IDLE;
                    issuing_reg <= 1'b0;
                end
            endcase
        end
    end

    assign m_valid         = m_valid_reg;
    assign m_product_value = m_product_reg;
    assign m_out_row       = m_row_reg;
    assign m_out_col       = m_col_reg;

endmodule
